// ===== src/i2ccds_pkg.sv =====
// ----------------------------------------------------------------------------
// i2ccds_pkg: shared types and constants
// Command and status words between the search controller and its datapath,
// divider operand selects and the outcome codes.
// ----------------------------------------------------------------------------
package i2ccds_pkg;

  localparam int unsigned RATE_BITS    = 22;
  localparam int unsigned WORD_BITS    = 32;
  localparam logic [31:0] SRC_PRESCALE = 32'd10;
  localparam logic [31:0] CLOCK_RESET  = 32'd24000000;

  // divide by SRC_PRESCALE: multiply by ceil(2^35 / 10), keep bits 35 and up
  localparam logic [31:0] SRC_RECIP       = 32'hCCCC_CCCD;
  localparam int unsigned SRC_RECIP_SHIFT = 35;

  // outcome codes
  localparam logic [1:0] OUTCOME_FOUND = 2'd0;
  localparam logic [1:0] OUTCOME_ZERO  = 2'd1;
  localparam logic [1:0] OUTCOME_NONE  = 2'd2;

  // operand select for the shared divider
  typedef enum logic [1:0] {
    DIV_OP_BASE,
    DIV_OP_REAL
  } div_op_e;

  typedef struct packed {
    logic       load_req;
    logic       div_start;
    div_op_e    div_op;
    logic       save_src;
    logic       save_div;
    logic       init_n;
    logic       next_n;
    logic       init_m;
    logic       inc_m;
    logic       finish;
    logic [1:0] outcome;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic req_zero;
    logic div_zero;
    logic skip_n;
    logic n_last;
    logic m_last;
    logic real_le;
  } status_t;

endpackage

// ===== src/i2ccds_div.sv =====
// ----------------------------------------------------------------------------
// i2ccds_div: 32-bit restoring divider
// One quotient bit per cycle; done pulses for one cycle after 32 steps and
// the quotient holds until the next start.
// ----------------------------------------------------------------------------
module i2ccds_div import i2ccds_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_BITS-1:0] dividend_i,
  input  logic [WORD_BITS-1:0] divisor_i,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] quotient_o
);

  logic [WORD_BITS-1:0] rem_q, rem_d;
  logic [WORD_BITS-1:0] quo_q, quo_d;
  logic [WORD_BITS-1:0] dsr_q;
  logic [4:0]           cnt_q;
  logic                 run_q;
  logic                 done_q;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS:0]   diff;

  // shift in the next dividend bit and try a subtraction
  always_comb begin
    trial = {rem_q, quo_q[WORD_BITS-1]};
    diff  = trial - {1'b0, dsr_q};
    quo_d = {quo_q[WORD_BITS-2:0], ~diff[WORD_BITS]};
    rem_d = diff[WORD_BITS] ? trial[WORD_BITS-1:0] : diff[WORD_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 5'd31;
      end else if (run_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== src/i2ccds_dp.sv =====
// ----------------------------------------------------------------------------
// i2ccds_dp: search datapath
// Holds the clock register, request, source clock, base divider and the
// (n, m) candidate; runs the shared divider and forms the result word.
// ----------------------------------------------------------------------------
module i2ccds_dp import i2ccds_pkg::*; #(
  parameter int unsigned N_FIELD_BITS = 3,
  parameter int unsigned M_FIELD_BITS = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [WORD_BITS-1:0]    cfg_data_i,
  input  logic [RATE_BITS-1:0]    req_i,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  output logic                    done_o,
  output logic [N_FIELD_BITS-1:0] exponent_n_o,
  output logic [M_FIELD_BITS-1:0] linear_m_o,
  output logic [1:0]              outcome_o
);

  localparam logic [WORD_BITS-1:0] M_SPAN = WORD_BITS'(1) << M_FIELD_BITS;

  logic [WORD_BITS-1:0]    clk_hz_q;
  logic [RATE_BITS-1:0]    req_q;
  logic [WORD_BITS-1:0]    src_q;
  logic [WORD_BITS-1:0]    base_q;
  logic [N_FIELD_BITS-1:0] n_q;
  logic [M_FIELD_BITS-1:0] m_q;
  logic [N_FIELD_BITS-1:0] res_n_q;
  logic [M_FIELD_BITS-1:0] res_m_q;
  logic [1:0]              res_out_q;
  logic                    done_q;

  logic [WORD_BITS-1:0]    dividend;
  logic [WORD_BITS-1:0]    divisor;
  logic                    div_done;
  logic [WORD_BITS-1:0]    quotient;
  logic [WORD_BITS-1:0]    start_val;
  logic [WORD_BITS-1:0]    real_rate;
  logic [2*WORD_BITS-1:0]  src_prod;

  // source clock by reciprocal multiply
  assign src_prod = {{WORD_BITS{1'b0}}, clk_hz_q} * {{WORD_BITS{1'b0}}, SRC_RECIP};

  always_comb begin
    unique case (cmd_i.div_op)
      DIV_OP_BASE: begin
        dividend = src_q;
        divisor  = WORD_BITS'(req_q);
      end
      DIV_OP_REAL: begin
        dividend = src_q;
        divisor  = WORD_BITS'(m_q) + WORD_BITS'(1);
      end
      default: begin
        dividend = src_q;
        divisor  = WORD_BITS'(req_q);
      end
    endcase
  end

  i2ccds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign start_val = base_q >> n_q;
  assign real_rate = quotient >> n_q;

  always_comb begin
    status_o.div_done = div_done;
    status_o.req_zero = (req_q == '0);
    status_o.div_zero = (base_q == '0);
    status_o.skip_n   = (start_val == '0) || (start_val > M_SPAN);
    status_o.n_last   = (n_q == '1);
    status_o.m_last   = (m_q == '1);
    status_o.real_le  = (real_rate <= WORD_BITS'(req_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= CLOCK_RESET;
      done_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        clk_hz_q <= cfg_data_i;
      end
      done_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    if (cmd_i.save_src) src_q <= WORD_BITS'(src_prod[2*WORD_BITS-1:SRC_RECIP_SHIFT]);
    if (cmd_i.save_div) base_q <= quotient;
    if (cmd_i.init_n) begin
      n_q <= '0;
    end else if (cmd_i.next_n) begin
      n_q <= n_q + N_FIELD_BITS'(1);
    end
    if (cmd_i.init_m) begin
      m_q <= M_FIELD_BITS'(start_val - WORD_BITS'(1));
    end else if (cmd_i.inc_m) begin
      m_q <= m_q + M_FIELD_BITS'(1);
    end
    if (cmd_i.finish) begin
      res_out_q <= cmd_i.outcome;
      unique case (cmd_i.outcome)
        OUTCOME_FOUND: begin
          res_n_q <= n_q;
          res_m_q <= m_q;
        end
        OUTCOME_NONE: begin
          res_n_q <= '1;
          res_m_q <= '1;
        end
        default: begin
          res_n_q <= '0;
          res_m_q <= '0;
        end
      endcase
    end
  end

  assign done_o       = done_q;
  assign exponent_n_o = res_n_q;
  assign linear_m_o   = res_m_q;
  assign outcome_o    = res_out_q;

endmodule

// ===== src/i2ccds_ctrl.sv =====
// ----------------------------------------------------------------------------
// i2ccds_ctrl: search sequencer
// Steps through source clock, base divider and the (n, m) trials, issuing
// datapath commands and finishing with one result word.
// ----------------------------------------------------------------------------
module i2ccds_ctrl import i2ccds_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE_GO,
    ST_BASE,
    ST_CHK,
    ST_N,
    ST_M_GO,
    ST_M
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load_req = 1'b1;
          cmd_o.save_src = 1'b1;
          state_d        = ST_BASE_GO;
        end
      end
      ST_BASE_GO: begin
        if (status_i.req_zero) begin
          cmd_o.finish  = 1'b1;
          cmd_o.outcome = OUTCOME_ZERO;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_op    = DIV_OP_BASE;
          state_d         = ST_BASE;
        end
      end
      ST_BASE: begin
        if (status_i.div_done) begin
          cmd_o.save_div = 1'b1;
          state_d        = ST_CHK;
        end
      end
      ST_CHK: begin
        if (status_i.div_zero) begin
          cmd_o.finish  = 1'b1;
          cmd_o.outcome = OUTCOME_ZERO;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.init_n = 1'b1;
          state_d      = ST_N;
        end
      end
      ST_N: begin
        if (!status_i.skip_n) begin
          cmd_o.init_m = 1'b1;
          state_d      = ST_M_GO;
        end else if (status_i.n_last) begin
          cmd_o.finish  = 1'b1;
          cmd_o.outcome = OUTCOME_NONE;
          state_d       = ST_IDLE;
        end else begin
          cmd_o.next_n = 1'b1;
        end
      end
      ST_M_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_OP_REAL;
        state_d         = ST_M;
      end
      ST_M: begin
        cmd_o.div_op = DIV_OP_REAL;
        if (status_i.div_done) begin
          priority if (status_i.real_le) begin
            cmd_o.finish  = 1'b1;
            cmd_o.outcome = OUTCOME_FOUND;
            state_d       = ST_IDLE;
          end else if (!status_i.m_last) begin
            cmd_o.inc_m = 1'b1;
            state_d     = ST_M_GO;
          end else if (status_i.n_last) begin
            cmd_o.finish  = 1'b1;
            cmd_o.outcome = OUTCOME_NONE;
            state_d       = ST_IDLE;
          end else begin
            cmd_o.next_n = 1'b1;
            state_d      = ST_N;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// ===== src/i2c_clock_divider_search_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_clock_divider_search_unit: two-wire bus clock divider search
// Finds the exponent n and linear factor m so that the bus clock
// floor(floor(src / (m + 1)) / 2^n) does not exceed the requested rate.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                    | handshake
//  ----------+--------------------------------------------+-------------------
//  request   | requested_rate_hz_i                        | start & !busy
//  result    | exponent_n_o, linear_m_o, outcome_o        | done_o, one cycle
//  config    | cfg_data_i (input_clock_hz)                | cfg_valid_i & ready
//
//  Flow: src comes from a reciprocal multiply in the accept cycle; the base
//  divider and each (n, m) trial use one shared 32-step divider, and there
//  are at most 2^(N + M) trials; a zero request ends the search before the
//  base division, a zero divider right after it.
//  Reset loads input_clock_hz with 24 MHz; the receiver cannot stall, and
//  cfg_ready_o stays high: write the clock register only while idle.
// ----------------------------------------------------------------------------
module i2c_clock_divider_search_unit import i2ccds_pkg::*; #(
  parameter int unsigned N_FIELD_BITS = 3,
  parameter int unsigned M_FIELD_BITS = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // request word
  input  logic                    start,
  output logic                    busy,
  input  logic [RATE_BITS-1:0]    requested_rate_hz_i,
  // result word
  output logic                    done_o,
  output logic [N_FIELD_BITS-1:0] exponent_n_o,
  output logic [M_FIELD_BITS-1:0] linear_m_o,
  output logic [1:0]              outcome_o,
  // clock register write
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [WORD_BITS-1:0]    cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  // accept register writes every cycle
  assign cfg_ready_o = 1'b1;

  // sequencer: accepts a request word when idle, drives datapath commands
  i2ccds_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // datapath: registers, shared divider, compare and result word
  i2ccds_dp #(
    .N_FIELD_BITS (N_FIELD_BITS),
    .M_FIELD_BITS (M_FIELD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .req_i        (requested_rate_hz_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .done_o       (done_o),
    .exponent_n_o (exponent_n_o),
    .linear_m_o   (linear_m_o),
    .outcome_o    (outcome_o)
  );

`ifndef NO_ASSERTIONS
  // result word arrives only after the sequencer went back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // an accepted request always starts a search
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not start a search");

  // outcome carries a defined code
  a_outcome_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (outcome_o == OUTCOME_FOUND || outcome_o == OUTCOME_ZERO ||
                outcome_o == OUTCOME_NONE))
    else $error("undefined outcome code");

  // zero request or divider reports cleared fields
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && outcome_o == OUTCOME_ZERO) |-> (exponent_n_o == '0 && linear_m_o == '0))
    else $error("zero outcome with nonzero fields");
`endif

endmodule

// ===== test/i2c_clock_divider_search_checker.sv =====
// ----------------------------------------------------------------------------
// i2c_clock_divider_search_checker: result predictor and scoreboard
// Tracks the clock register, predicts the (n, m, outcome) setting for every
// accepted rate word and compares each result word against it in order.
// ----------------------------------------------------------------------------
module i2c_clock_divider_search_checker import i2ccds_pkg::*; #(
  parameter int unsigned N_FIELD_BITS = 3,
  parameter int unsigned M_FIELD_BITS = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  logic [RATE_BITS-1:0]    requested_rate_hz_i,
  input  logic                    done_i,
  input  logic [N_FIELD_BITS-1:0] exponent_n_i,
  input  logic [M_FIELD_BITS-1:0] linear_m_i,
  input  logic [1:0]              outcome_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [WORD_BITS-1:0]    cfg_data_i,
  output int unsigned             mismatch_count_o,
  output int unsigned             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] N_LAST = (32'd1 << N_FIELD_BITS) - 32'd1;
  localparam logic [31:0] M_LAST = (32'd1 << M_FIELD_BITS) - 32'd1;

  typedef struct packed {
    logic [N_FIELD_BITS-1:0] exponent_n;
    logic [M_FIELD_BITS-1:0] linear_m;
    logic [1:0]              outcome;
  } divider_setting_t;

  logic [WORD_BITS-1:0] input_clock_hz;
  divider_setting_t     expected_settings[$];

  // Walk the exponents in order; for each, raise m from floor(div / 2^n) - 1
  // until the bus rate drops to the request or m leaves its range.
  function automatic divider_setting_t search_divider(input logic [31:0] clock_hz,
                                                      input logic [RATE_BITS-1:0] rate);
    logic [31:0]      src_hz;
    logic [31:0]      req_hz;
    logic [31:0]      base_div;
    logic [31:0]      first_m;
    logic [31:0]      bus_hz;
    logic [31:0]      n;
    logic [31:0]      m;
    divider_setting_t setting;
    setting.exponent_n = '0;
    setting.linear_m   = '0;
    setting.outcome    = OUTCOME_ZERO;
    req_hz = 32'(rate);
    src_hz = clock_hz / SRC_PRESCALE;
    if (req_hz == 32'd0) return setting;
    base_div = src_hz / req_hz;
    if (base_div == 32'd0) return setting;
    for (n = 32'd0; n <= N_LAST; n++) begin
      first_m = base_div >> n;
      if (first_m != 32'd0) begin
        for (m = first_m - 32'd1; m <= M_LAST; m++) begin
          bus_hz = (src_hz / (m + 32'd1)) >> n;
          if (bus_hz <= req_hz) begin
            setting.exponent_n = n[N_FIELD_BITS-1:0];
            setting.linear_m   = m[M_FIELD_BITS-1:0];
            setting.outcome    = OUTCOME_FOUND;
            return setting;
          end
        end
      end
    end
    setting.exponent_n = N_LAST[N_FIELD_BITS-1:0];
    setting.linear_m   = M_LAST[M_FIELD_BITS-1:0];
    setting.outcome    = OUTCOME_NONE;
    return setting;
  endfunction

  assign pending_o = expected_settings.size();

  always @(posedge clk_i or negedge rst_ni) begin
    divider_setting_t want;
    if (!rst_ni) begin
      input_clock_hz   <= CLOCK_RESET;
      mismatch_count_o <= 0;
      expected_settings.delete();
    end else begin
      // compare before push: a result never belongs to a word taken at this edge
      if (done_i) begin
        if (expected_settings.size() == 0) begin
          $display("%0t: unexpected result word n=%0d m=%0d outcome=%0d",
                   $time, exponent_n_i, linear_m_i, outcome_i);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          want = expected_settings.pop_front();
          if (want.exponent_n !== exponent_n_i || want.linear_m !== linear_m_i ||
              want.outcome !== outcome_i) begin
            $display("%0t: mismatch expected n=%0d m=%0d outcome=%0d, actual n=%0d m=%0d outcome=%0d",
                     $time, want.exponent_n, want.linear_m, want.outcome,
                     exponent_n_i, linear_m_i, outcome_i);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      if (start_i && !busy_i)
        expected_settings.push_back(search_divider(input_clock_hz, requested_rate_hz_i));
      if (cfg_valid_i && cfg_ready_i)
        input_clock_hz <= cfg_data_i;
    end
  end

endmodule

// ===== test/i2c_clock_divider_search_unit_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_clock_divider_search_unit_tb: divider search testbench
// Drives rate words and clock register writes into the search unit across
// several clock settings, with sender gaps; the checker predicts every
// result word and counts mismatches, this module gives the verdict.
// ----------------------------------------------------------------------------
module i2c_clock_divider_search_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2ccds_pkg::*;

  localparam int unsigned N_FIELD_BITS = 3;
  localparam int unsigned M_FIELD_BITS = 4;
  localparam logic [RATE_BITS-1:0] RATE_MAX = '1;
  localparam int unsigned RANDOM_WORDS = 430;
  localparam int unsigned SETTLE_CYCLES = 200;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [RATE_BITS-1:0]    requested_rate_hz_i;
  logic                    done_o;
  logic [N_FIELD_BITS-1:0] exponent_n_o;
  logic [M_FIELD_BITS-1:0] linear_m_o;
  logic [1:0]              outcome_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [WORD_BITS-1:0]    cfg_data_i;

  int unsigned mismatch_count;
  int unsigned pending_count;

  // clock register value as last written, used to aim rates at the boundaries
  logic [WORD_BITS-1:0] clock_setting;
  int unsigned          words_sent;
  int unsigned          gap_percent;

  i2c_clock_divider_search_unit #(
    .N_FIELD_BITS(N_FIELD_BITS),
    .M_FIELD_BITS(M_FIELD_BITS)
  ) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .requested_rate_hz_i(requested_rate_hz_i),
    .done_o             (done_o),
    .exponent_n_o       (exponent_n_o),
    .linear_m_o         (linear_m_o),
    .outcome_o          (outcome_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i)
  );

  i2c_clock_divider_search_checker #(
    .N_FIELD_BITS(N_FIELD_BITS),
    .M_FIELD_BITS(M_FIELD_BITS)
  ) search_check (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .busy_i             (busy),
    .requested_rate_hz_i(requested_rate_hz_i),
    .done_i             (done_o),
    .exponent_n_i       (exponent_n_o),
    .linear_m_i         (linear_m_o),
    .outcome_i          (outcome_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .mismatch_count_o   (mismatch_count),
    .pending_o          (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Slowest legal run: ~450 words, each up to 129 divisions, plus sender
  // gaps; that is under 10 ms. Allow several times that.
  initial begin
    #60_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Send one rate word. Optionally idle first, then hold start high until
  // the unit takes the word; busy is sampled mid-cycle to stay clear of
  // the edge. Returns right after the accepting edge.
  task automatic send_rate(input logic [RATE_BITS-1:0] rate);
    if ($urandom_range(99) < gap_percent) begin
      start <= 1'b0;
      requested_rate_hz_i <= RATE_BITS'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    requested_rate_hz_i <= rate;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    words_sent++;
  endtask

  // Drain every expected result, then write the clock register while idle.
  task automatic write_clock(input logic [WORD_BITS-1:0] clock_hz);
    start <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0 || busy);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= clock_hz;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= $urandom;
    clock_setting = clock_hz;
  endtask

  // Pick a rate: most often aimed near src / ((m + 1) * 2^n) so the search
  // lands on varied exponents, plus full-range, log-spread and edge values.
  function automatic logic [RATE_BITS-1:0] pick_rate();
    logic [31:0] src_hz;
    logic [32:0] aimed;
    int unsigned width;
    src_hz = clock_setting / SRC_PRESCALE;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0:       return '0;
          1:       return RATE_BITS'(1);
          2:       return RATE_MAX;
          default: return RATE_BITS'(1) << $urandom_range(RATE_BITS - 1);
        endcase
      end
      1, 2: return RATE_BITS'($urandom);
      3, 4, 5: begin
        width = $urandom_range(1, RATE_BITS);
        return RATE_BITS'($urandom & ((33'd1 << width) - 33'd1));
      end
      default: begin
        aimed = 33'(src_hz / $urandom_range(1, 2200)) + 33'($urandom_range(2)) - 33'd1;
        if (aimed > 33'(RATE_MAX)) aimed = 33'(RATE_MAX);
        return RATE_BITS'(aimed);
      end
    endcase
  endfunction

  initial begin
    logic [RATE_BITS-1:0] corner_rates[$];
    logic [WORD_BITS-1:0] clock_plan[$];
    int unsigned          words_per_clock;

    start               <= 1'b0;
    requested_rate_hz_i <= '0;
    cfg_valid_i         <= 1'b0;
    cfg_data_i          <= '0;
    rst_ni              = 1'b0;
    clock_setting       = CLOCK_RESET;
    words_sent          = 0;
    gap_percent         = 33;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset clock (src = 2.4 MHz): zero request,
    // zero divider, nothing fits, exact fits, m rising past its start,
    // exponent zero skipped for a start above the m range, bit patterns.
    corner_rates = '{22'd0, 22'd1, RATE_MAX, 22'd2400000, 22'd2400001, 22'd2000000,
                     22'd240000, 22'd150000, 22'd141176, 22'd18750, 22'd18749,
                     22'd9375, 22'd100000, 22'd400000, 22'd1000, 22'h2AAAAA,
                     22'h155555};
    foreach (corner_rates[i]) send_rate(corner_rates[i]);

    // Sweep clock settings, extremes among them; end on the reset value.
    clock_plan = '{32'd100_000_000, 32'hFFFF_FFFF, 32'd0, 32'd9, 32'd10,
                   $urandom, 32'd400_000, CLOCK_RESET};
    words_per_clock = RANDOM_WORDS / clock_plan.size();
    foreach (clock_plan[p]) begin
      write_clock(clock_plan[p]);
      repeat (words_per_clock) begin
        // sender gaps: light first, heavy next, none for the last stretch
        if (words_sent < 170)      gap_percent = 33;
        else if (words_sent < 320) gap_percent = 62;
        else                       gap_percent = 0;
        send_rate(pick_rate());
      end
    end
    start <= 1'b0;

    // Drain, then hold a little longer to catch a stray result word.
    do @(negedge clk_i); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
